// ===== rtl/tcsnk_pkg.sv =====
// Shared types and constants for the Type-C sink attach state machine.
// No dependencies; used by typec_sink_attach_fsm.
package tcsnk_pkg;

  localparam int unsigned CntW    = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_VBUS_DEBOUNCE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_CC_POLL       = 8'd1;

  localparam logic [CntW-1:0] VBUS_DEBOUNCE_RST = 16'd100;
  localparam logic [CntW-1:0] CC_POLL_RST       = 16'd20;

  // connection state codes
  localparam logic [1:0] ST_DETACHED  = 2'd0;
  localparam logic [1:0] ST_DETECTING = 2'd1;
  localparam logic [1:0] ST_ATTACHED  = 2'd2;

  // polarity codes
  localparam logic [1:0] POL_NONE = 2'd0;
  localparam logic [1:0] POL_CC1  = 2'd1;
  localparam logic [1:0] POL_CC2  = 2'd2;

  typedef struct packed {
    logic [1:0] cc2_level;
    logic [1:0] cc1_level;
    logic       polarity_done;
    logic       vbus_ok;
    logic       tick;
  } status_t;

  typedef struct packed {
    logic [1:0] polarity_value;
    logic       polarity_request;
    logic       scan_request;
    logic       attached;
    logic [1:0] conn_state;
  } result_t;

endpackage

// ===== rtl/typec_sink_attach_fsm.sv =====
// Type-C sink attach state machine: detached, detecting, sink attached.
// Depends on tcsnk_pkg for codes and beat layouts.
//
// Each input beat is one system update (timer tick plus port controller
// status) and yields exactly one result beat. The state update and the
// result are computed combinationally from the state registers and the
// input beat and land in an output register, so one beat is taken per
// clock while the output is not stalled; in_tready only drops when the
// output register is full and the sink is stalling. The first result
// after reset requests polarity "none". Configuration writes are always
// accepted and apply to the next beat; an unknown index is ignored.
module typec_sink_attach_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // tick, vbus_ok, polarity_done, cc1_level[1:0],
                                  // cc2_level[1:0], zero pad
  input  logic        in_tuser,   // scan_valid
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // conn_state[1:0], attached, scan_request,
                                  // polarity_request, polarity_value[1:0], zero pad
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tcsnk_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tcsnk_pkg::CfgDatW-1:0] cfg_data
);

  localparam int unsigned CntW = tcsnk_pkg::CntW;

  logic [CntW-1:0] vbus_deb_ticks_r;
  logic [CntW-1:0] cc_poll_ticks_r;

  logic [1:0]      state_r, state_nxt;
  logic            deb_run_r, deb_run_nxt;
  logic [CntW-1:0] deb_cnt_r, deb_cnt_nxt;
  logic            poll_run_r, poll_run_nxt;
  logic [CntW-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [1:0]      last_cc1_r, last_cc1_nxt;
  logic [1:0]      last_cc2_r, last_cc2_nxt;
  logic            att_r, att_nxt;
  logic            pol_pend_r;

  logic                 out_valid_r;
  tcsnk_pkg::result_t   res_r, res_nxt;

  tcsnk_pkg::status_t st;
  logic               scan_valid;
  logic               in_beat;
  logic               req_scan, req_pol;
  logic [1:0]         req_pol_val;
  logic [CntW-1:0]    deb_cnt_inc, poll_cnt_inc;
  logic               go;

  assign st         = tcsnk_pkg::status_t'(in_tdata[6:0]);
  assign scan_valid = in_tuser;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  // saturating tick counters, advanced before the state is evaluated
  always_comb begin
    deb_cnt_inc  = deb_cnt_r;
    poll_cnt_inc = poll_cnt_r;
    if (st.tick && deb_run_r && deb_cnt_r != '1) begin
      deb_cnt_inc = deb_cnt_r + 1'b1;
    end
    if (st.tick && poll_run_r && poll_cnt_r != '1) begin
      poll_cnt_inc = poll_cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    deb_run_nxt  = deb_run_r;
    deb_cnt_nxt  = deb_cnt_inc;
    poll_run_nxt = poll_run_r;
    poll_cnt_nxt = poll_cnt_inc;
    last_cc1_nxt = last_cc1_r;
    last_cc2_nxt = last_cc2_r;
    att_nxt      = att_r;
    req_scan     = 1'b0;
    req_pol      = pol_pend_r;
    req_pol_val  = tcsnk_pkg::POL_NONE;
    go           = 1'b1;

    unique case (state_r)
      tcsnk_pkg::ST_DETECTING: begin
        if (poll_run_r) begin
          if (poll_cnt_inc < cc_poll_ticks_r) begin
            go = 1'b0;
          end else begin
            poll_run_nxt = 1'b0;
            poll_cnt_nxt = '0;
            req_scan     = 1'b1;
          end
        end
        if (go && scan_valid) begin
          if (!st.vbus_ok) begin
            poll_run_nxt = 1'b0;
            poll_cnt_nxt = '0;
            state_nxt    = tcsnk_pkg::ST_DETACHED;
            att_nxt      = 1'b0;
            deb_run_nxt  = 1'b0;
            deb_cnt_nxt  = '0;
            req_pol      = 1'b1;
            req_pol_val  = tcsnk_pkg::POL_NONE;
          end else if (st.cc1_level != st.cc2_level && st.cc1_level == last_cc1_r &&
                       st.cc2_level == last_cc2_r) begin
            req_pol      = 1'b1;
            req_pol_val  = (st.cc1_level > st.cc2_level) ? tcsnk_pkg::POL_CC1
                                                         : tcsnk_pkg::POL_CC2;
            poll_run_nxt = 1'b0;
            poll_cnt_nxt = '0;
            state_nxt    = tcsnk_pkg::ST_ATTACHED;
            att_nxt      = 1'b1;
          end else begin
            last_cc1_nxt = st.cc1_level;
            last_cc2_nxt = st.cc2_level;
            poll_run_nxt = 1'b1;
            poll_cnt_nxt = '0;
          end
        end
      end
      tcsnk_pkg::ST_ATTACHED: begin
        if (!att_r && st.polarity_done) begin
          att_nxt = 1'b1;
        end
        if (!st.vbus_ok) begin
          state_nxt   = tcsnk_pkg::ST_DETACHED;
          att_nxt     = 1'b0;
          deb_run_nxt = 1'b0;
          deb_cnt_nxt = '0;
          req_pol     = 1'b1;
          req_pol_val = tcsnk_pkg::POL_NONE;
        end
      end
      default: begin
        // detached, and the unused code falls back to detached
        state_nxt = tcsnk_pkg::ST_DETACHED;
        if (st.polarity_done) begin
          if (!st.vbus_ok) begin
            deb_run_nxt = 1'b0;
            deb_cnt_nxt = '0;
          end else if (!deb_run_r) begin
            deb_run_nxt = 1'b1;
            deb_cnt_nxt = '0;
          end else if (deb_cnt_inc >= vbus_deb_ticks_r) begin
            deb_run_nxt  = 1'b0;
            deb_cnt_nxt  = '0;
            state_nxt    = tcsnk_pkg::ST_DETECTING;
            last_cc1_nxt = 2'd0;
            last_cc2_nxt = 2'd0;
            req_scan     = 1'b1;
            poll_run_nxt = 1'b0;
            poll_cnt_nxt = '0;
          end
        end
      end
    endcase

    res_nxt.conn_state       = state_nxt;
    res_nxt.attached         = att_nxt;
    res_nxt.scan_request     = req_scan;
    res_nxt.polarity_request = req_pol;
    res_nxt.polarity_value   = req_pol ? req_pol_val : tcsnk_pkg::POL_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbus_deb_ticks_r <= tcsnk_pkg::VBUS_DEBOUNCE_RST;
      cc_poll_ticks_r  <= tcsnk_pkg::CC_POLL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcsnk_pkg::REG_VBUS_DEBOUNCE: vbus_deb_ticks_r <= cfg_data;
        tcsnk_pkg::REG_CC_POLL:       cc_poll_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcsnk_pkg::ST_DETACHED;
      deb_run_r   <= 1'b0;
      deb_cnt_r   <= '0;
      poll_run_r  <= 1'b0;
      poll_cnt_r  <= '0;
      last_cc1_r  <= 2'd0;
      last_cc2_r  <= 2'd0;
      att_r       <= 1'b0;
      pol_pend_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        state_r    <= state_nxt;
        deb_run_r  <= deb_run_nxt;
        deb_cnt_r  <= deb_cnt_nxt;
        poll_run_r <= poll_run_nxt;
        poll_cnt_r <= poll_cnt_nxt;
        last_cc1_r <= last_cc1_nxt;
        last_cc2_r <= last_cc2_nxt;
        att_r      <= att_nxt;
        pol_pend_r <= 1'b0;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule
